/* rtl/http_request_end_detector_assert.svh */
// Assertion macros for the HTTP request end detector.
// Depends on nothing; included by the files that carry assertions.
`ifndef HTTP_REQUEST_END_DETECTOR_ASSERT_SVH
`define HTTP_REQUEST_END_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRED_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hred_pkg.sv */
// Types, character constants and name tables for the HTTP request end detector.
// Depends on nothing; used by http_request_end_detector and the bench.
package hred_pkg;

    localparam int COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [3:0] NAME_LEN = 4'd14;

    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = " ";
    localparam logic [7:0] CHAR_ZERO    = "0";
    localparam logic [7:0] CHAR_NINE    = "9";
    localparam logic [7:0] CHAR_LOWER_A = "a";
    localparam logic [7:0] CHAR_LOWER_Z = "z";
    localparam logic [7:0] CHAR_CASE    = 8'd32;
    localparam logic [7:0] CHAR_G       = "G";
    localparam logic [7:0] CHAR_P       = "P";
    localparam logic [7:0] CHAR_D       = "D";
    localparam logic [7:0] CHAR_U       = "U";
    localparam logic [7:0] CHAR_C       = "C";

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [2:0] {
        METH_NONE    = 3'd0,
        METH_GET     = 3'd1,
        METH_POST    = 3'd2,
        METH_PUT     = 3'd3,
        METH_DELETE  = 3'd4,
        METH_UNKNOWN = 3'd5
    } method_t;

    typedef enum logic [4:0] {
        VP_IDLE   = 5'b00001,
        VP_SKIP1  = 5'b00010,
        VP_SKIP2  = 5'b00100,
        VP_SPACES = 5'b01000,
        VP_DIGITS = 5'b10000
    } value_phase_t;

    typedef enum logic [4:0] {
        TERM_NONE    = 5'b00001,
        TERM_CR      = 5'b00010,
        TERM_LF      = 5'b00100,
        TERM_CRLF    = 5'b01000,
        TERM_CRLFCR  = 5'b10000
    } term_t;

    function automatic logic [2:0] meth_len(method_t m);
        case (m)
            METH_GET:    meth_len = 3'd3;
            METH_POST:   meth_len = 3'd4;
            METH_PUT:    meth_len = 3'd3;
            METH_DELETE: meth_len = 3'd6;
            default:     meth_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] meth_char(method_t m, logic [2:0] pos);
        logic [47:0] text;
        case (m)
            METH_GET:    text = {"GET", 24'd0};
            METH_POST:   text = {"POST", 16'd0};
            METH_PUT:    text = {"PUT", 24'd0};
            METH_DELETE: text = "DELETE";
            default:     text = 48'd0;
        endcase
        case (pos)
            3'd0:    meth_char = text[47:40];
            3'd1:    meth_char = text[39:32];
            3'd2:    meth_char = text[31:24];
            3'd3:    meth_char = text[23:16];
            3'd4:    meth_char = text[15:8];
            3'd5:    meth_char = text[7:0];
            default: meth_char = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] name_char(logic [3:0] idx);
        logic [111:0] text;
        text = "CONTENT-LENGTH";
        case (idx)
            4'd0:    name_char = text[111:104];
            4'd1:    name_char = text[103:96];
            4'd2:    name_char = text[95:88];
            4'd3:    name_char = text[87:80];
            4'd4:    name_char = text[79:72];
            4'd5:    name_char = text[71:64];
            4'd6:    name_char = text[63:56];
            4'd7:    name_char = text[55:48];
            4'd8:    name_char = text[47:40];
            4'd9:    name_char = text[39:32];
            4'd10:   name_char = text[31:24];
            4'd11:   name_char = text[23:16];
            4'd12:   name_char = text[15:8];
            4'd13:   name_char = text[7:0];
            default: name_char = 8'd0;
        endcase
    endfunction

endpackage

/* rtl/http_request_end_detector.sv */
// HTTP request end detector: method, header end, Content-Length and body tracking.
// Depends on hred_pkg and http_request_end_detector_assert.svh.
//
// Usage:
//   Input channel s_*: one item per request byte (s_op = data) or a restart
//   (s_op = restart) that returns all tracking state to its reset values.
//   Result channel m_*: exactly one result item per input item, showing the
//   method, header flag, parsed length, body byte count and end-of-request flag
//   after that item has been applied.
//   Latency: the result of an item is valid in the cycle after its acceptance.
//   Throughput: one item per cycle with m_ready high; the per-byte state update
//   is a single pass, longest path the decimal length step (x10, add, compare).
//   The state registers double as the result register, so s_ready is high
//   whenever the result register is empty or being drained this cycle.
//   Receiver stall: the result holds and s_ready drops until m_ready returns;
//   no item is lost or repeated.
//   Reset (aresetn low, synchronous): no result pending, method undecided,
//   in header, length and count zero.
module http_request_end_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_method,
    output logic        m_in_header,
    output logic [31:0] m_content_length,
    output logic [31:0] m_body_count,
    output logic        m_stream_end
);

`include "http_request_end_detector_assert.svh"

    localparam int CB = hred_pkg::COUNT_BITS;

    logic                  m_valid_reg, m_valid_next;
    hred_pkg::method_t     method_reg, method_next;
    hred_pkg::method_t     cand_reg, cand_next;
    logic [2:0]            pos_reg, pos_next;
    logic                  header_reg, header_next;
    hred_pkg::term_t       term_reg, term_next;
    logic [3:0]            name_reg, name_next;
    hred_pkg::value_phase_t phase_reg, phase_next;
    logic [CB-1:0]         length_reg, length_next;
    logic [CB-1:0]         body_reg, body_next;

    logic                  s_accept;
    logic [7:0]            upper;
    hred_pkg::method_t     cand_w;
    logic                  first_bad;
    logic [2:0]            pos_inc;
    logic [3:0]            name_w;
    logic [3:0]            digit;
    logic [CB+3:0]         scaled;
    logic                  is_digit;
    logic                  term_hit;
    logic                  full;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid_next = s_accept || (m_valid_reg && !m_ready);

    always_comb begin
        if (s_data_byte inside {[hred_pkg::CHAR_LOWER_A:hred_pkg::CHAR_LOWER_Z]}) begin
            upper = s_data_byte - hred_pkg::CHAR_CASE;
        end else begin
            upper = s_data_byte;
        end
        is_digit = s_data_byte inside {[hred_pkg::CHAR_ZERO:hred_pkg::CHAR_NINE]};
        digit    = 4'(s_data_byte - hred_pkg::CHAR_ZERO);
        scaled   = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0}
                 + (CB+4)'(digit);
    end

    always_comb begin
        method_next = method_reg;
        cand_next   = cand_reg;
        pos_next    = pos_reg;
        header_next = header_reg;
        term_next   = term_reg;
        name_next   = name_reg;
        phase_next  = phase_reg;
        length_next = length_reg;
        body_next   = body_reg;
        cand_w      = cand_reg;
        first_bad   = 1'b0;
        pos_inc     = pos_reg + 3'd1;
        name_w      = name_reg;
        term_hit    = 1'b0;

        if (s_op == hred_pkg::OP_RESTART) begin
            method_next = hred_pkg::METH_NONE;
            cand_next   = hred_pkg::METH_NONE;
            pos_next    = 3'd0;
            header_next = 1'b1;
            term_next   = hred_pkg::TERM_NONE;
            name_next   = 4'd0;
            phase_next  = hred_pkg::VP_IDLE;
            length_next = '0;
            body_next   = '0;
        end else if (header_reg) begin
            // method prefix
            if (method_reg == hred_pkg::METH_NONE) begin
                if (pos_reg == 3'd0) begin
                    case (upper)
                        hred_pkg::CHAR_G: cand_w = hred_pkg::METH_GET;
                        hred_pkg::CHAR_P: cand_w = hred_pkg::METH_POST;
                        hred_pkg::CHAR_D: cand_w = hred_pkg::METH_DELETE;
                        default:          first_bad = 1'b1;
                    endcase
                end else if (pos_reg == 3'd1 && cand_reg == hred_pkg::METH_POST
                             && upper == hred_pkg::CHAR_U) begin
                    cand_w = hred_pkg::METH_PUT;
                end
                cand_next = cand_w;
                if (first_bad) begin
                    method_next = hred_pkg::METH_UNKNOWN;
                    cand_next   = cand_reg;
                end else if (pos_reg >= hred_pkg::meth_len(cand_w)
                             || hred_pkg::meth_char(cand_w, pos_reg) != upper) begin
                    method_next = hred_pkg::METH_UNKNOWN;
                end else begin
                    pos_next = pos_inc;
                    if (pos_inc >= hred_pkg::meth_len(cand_w)) begin
                        method_next = cand_w;
                    end
                end
            end

            // Content-Length name match and value parse
            case (phase_reg)
                hred_pkg::VP_IDLE: begin
                    if (length_reg == '0) begin
                        if (name_reg < hred_pkg::NAME_LEN
                            && upper == hred_pkg::name_char(name_reg)) begin
                            name_w = name_reg + 4'd1;
                        end else if (upper == hred_pkg::CHAR_C) begin
                            name_w = 4'd1;
                        end else begin
                            name_w = 4'd0;
                        end
                        if (name_w == hred_pkg::NAME_LEN) begin
                            name_next  = 4'd0;
                            phase_next = hred_pkg::VP_SKIP1;
                        end else begin
                            name_next = name_w;
                        end
                    end
                end
                hred_pkg::VP_SKIP1: phase_next = hred_pkg::VP_SKIP2;
                hred_pkg::VP_SKIP2: phase_next = hred_pkg::VP_SPACES;
                default: begin
                    if (is_digit) begin
                        if (scaled[CB+3:CB] != 4'd0) begin
                            length_next = hred_pkg::CNT_MAX;
                        end else begin
                            length_next = scaled[CB-1:0];
                        end
                        phase_next = hred_pkg::VP_DIGITS;
                    end else if (!(s_data_byte == hred_pkg::CHAR_SPACE
                                   && phase_reg == hred_pkg::VP_SPACES)) begin
                        phase_next = hred_pkg::VP_IDLE;
                    end
                end
            endcase

            // header terminator
            if (s_data_byte == hred_pkg::CHAR_LF) begin
                if (term_reg == hred_pkg::TERM_LF || term_reg == hred_pkg::TERM_CRLF
                    || term_reg == hred_pkg::TERM_CRLFCR) begin
                    term_hit  = 1'b1;
                    term_next = hred_pkg::TERM_NONE;
                end else if (term_reg == hred_pkg::TERM_CR) begin
                    term_next = hred_pkg::TERM_CRLF;
                end else begin
                    term_next = hred_pkg::TERM_LF;
                end
            end else if (s_data_byte == hred_pkg::CHAR_CR) begin
                if (term_reg == hred_pkg::TERM_CRLF) begin
                    term_next = hred_pkg::TERM_CRLFCR;
                end else begin
                    term_next = hred_pkg::TERM_CR;
                end
            end else begin
                term_next = hred_pkg::TERM_NONE;
            end
            if (term_hit) begin
                header_next = 1'b0;
                phase_next  = hred_pkg::VP_IDLE;
                name_next   = 4'd0;
            end
        end else if (length_reg != '0 && body_reg != hred_pkg::CNT_MAX) begin
            body_next = body_reg + CB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            method_reg  <= hred_pkg::METH_NONE;
            cand_reg    <= hred_pkg::METH_NONE;
            pos_reg     <= 3'd0;
            header_reg  <= 1'b1;
            term_reg    <= hred_pkg::TERM_NONE;
            name_reg    <= 4'd0;
            phase_reg   <= hred_pkg::VP_IDLE;
            length_reg  <= '0;
            body_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                method_reg <= method_next;
                cand_reg   <= cand_next;
                pos_reg    <= pos_next;
                header_reg <= header_next;
                term_reg   <= term_next;
                name_reg   <= name_next;
                phase_reg  <= phase_next;
                length_reg <= length_next;
                body_reg   <= body_next;
            end
        end
    end

    // end-of-request rule per method
    always_comb begin
        full = (body_reg == length_reg);
        case (method_reg)
            hred_pkg::METH_GET, hred_pkg::METH_DELETE:
                m_stream_end = !header_reg && (length_reg == '0 || full);
            hred_pkg::METH_POST, hred_pkg::METH_PUT:
                m_stream_end = !header_reg && full;
            default:
                m_stream_end = !header_reg && length_reg != '0 && full;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_method         = method_reg;
    assign m_in_header      = header_reg;
    assign m_content_length = 32'(length_reg);
    assign m_body_count     = 32'(body_reg);

    `HRED_ASSERT_IMPL(a_body_idle_parse, aclk, aresetn, !header_reg,
        phase_reg == hred_pkg::VP_IDLE && name_reg == 4'd0,
        "length parse active after header end")
    `HRED_ASSERT_IMPL(a_body_needs_length, aclk, aresetn, body_reg != '0,
        !header_reg && length_reg != '0, "body counted without header end or length")
    `HRED_ASSERT_IMPL(a_method_prefix, aclk, aresetn,
        method_reg == hred_pkg::METH_GET || method_reg == hred_pkg::METH_POST
        || method_reg == hred_pkg::METH_PUT || method_reg == hred_pkg::METH_DELETE,
        pos_reg == hred_pkg::meth_len(method_reg), "method decided before full prefix")
    `HRED_ASSERT_NEXT(a_restart_clears, aclk, aresetn,
        s_accept && s_op == hred_pkg::OP_RESTART,
        m_valid && m_method == hred_pkg::METH_NONE && m_in_header
        && length_reg == '0 && body_reg == '0, "restart did not clear state")

endmodule

/* bench/tb.sv */
// Self-checking bench for http_request_end_detector: request bytes and restarts in,
// one status item out per input item, compared against an in-bench request tracker.
// Depends on hred_pkg and the RTL of http_request_end_detector.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1650;
    localparam int QUIET_TAIL  = 150;
    localparam int CB          = hred_pkg::COUNT_BITS;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        hred_pkg::method_t method;
        logic              in_header;
        logic [31:0]       content_length;
        logic [31:0]       body_count;
        logic              stream_end;
    } request_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = hred_pkg::OP_DATA;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [2:0]  m_method;
    logic        m_in_header;
    logic [31:0] m_content_length;
    logic [31:0] m_body_count;
    logic        m_stream_end;

    byte_item_t      pending_bytes[$];
    request_status_t expected_status[$];
    logic            item_taken = 1'b0;
    int unsigned     send_gap = 0;
    int unsigned     hold_gap = 0;
    int unsigned     mismatches = 0;
    int unsigned     results_checked = 0;
    int unsigned     ends_seen = 0;
    int unsigned     bytes_sent = 0;
    int unsigned     restarts_sent = 0;

    string header_name = "CONTENT-LENGTH";
    string eol_crlf = "\015\012";
    string eol_lf = "\012";

    // request tracker state
    hred_pkg::method_t      req_method;
    hred_pkg::method_t      word_method;
    int unsigned            word_pos;
    int unsigned            name_pos;
    logic                   header_open;
    hred_pkg::term_t        line_state;
    hred_pkg::value_phase_t parse_phase;
    logic [CB-1:0]          length_seen;
    logic [CB-1:0]          body_seen;

    http_request_end_detector u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_method         (m_method),
        .m_in_header      (m_in_header),
        .m_content_length (m_content_length),
        .m_body_count     (m_body_count),
        .m_stream_end     (m_stream_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_request();
        req_method  = hred_pkg::METH_NONE;
        word_method = hred_pkg::METH_NONE;
        word_pos    = 0;
        name_pos    = 0;
        header_open = 1'b1;
        line_state  = hred_pkg::TERM_NONE;
        parse_phase = hred_pkg::VP_IDLE;
        length_seen = '0;
        body_seen   = '0;
    endfunction

    function automatic request_status_t advance_request(logic op, logic [7:0] b);
        logic [7:0]    u;
        logic [CB+3:0] grown;
        logic          done;
        logic          full;
        string         word;
        request_status_t r;
        if (op == hred_pkg::OP_RESTART) begin
            clear_request();
        end else begin
            u = (b >= hred_pkg::CHAR_LOWER_A && b <= hred_pkg::CHAR_LOWER_Z) ?
                b - hred_pkg::CHAR_CASE : b;
            if (header_open) begin
                if (req_method == hred_pkg::METH_NONE) begin
                    if (word_pos == 0)
                        word_method = (u == hred_pkg::CHAR_G) ? hred_pkg::METH_GET :
                                      (u == hred_pkg::CHAR_P) ? hred_pkg::METH_POST :
                                      (u == hred_pkg::CHAR_D) ? hred_pkg::METH_DELETE :
                                      hred_pkg::METH_UNKNOWN;
                    else if (word_pos == 1 && word_method == hred_pkg::METH_POST &&
                             u == hred_pkg::CHAR_U)
                        word_method = hred_pkg::METH_PUT;
                    case (word_method)
                        hred_pkg::METH_GET:    word = "GET";
                        hred_pkg::METH_POST:   word = "POST";
                        hred_pkg::METH_PUT:    word = "PUT";
                        hred_pkg::METH_DELETE: word = "DELETE";
                        default:               word = "";
                    endcase
                    if (word_pos >= word.len() || word[word_pos] != u) begin
                        req_method = hred_pkg::METH_UNKNOWN;
                    end else begin
                        word_pos++;
                        if (word_pos == word.len())
                            req_method = word_method;
                    end
                end
                case (parse_phase)
                    hred_pkg::VP_IDLE: begin
                        if (length_seen == 0) begin
                            if (name_pos < header_name.len() && u == header_name[name_pos])
                                name_pos++;
                            else
                                name_pos = (u == hred_pkg::CHAR_C) ? 1 : 0;
                            if (name_pos == header_name.len()) begin
                                name_pos = 0;
                                parse_phase = hred_pkg::VP_SKIP1;
                            end
                        end
                    end
                    hred_pkg::VP_SKIP1: parse_phase = hred_pkg::VP_SKIP2;
                    hred_pkg::VP_SKIP2: parse_phase = hred_pkg::VP_SPACES;
                    default: begin
                        if (b >= hred_pkg::CHAR_ZERO && b <= hred_pkg::CHAR_NINE) begin
                            grown = {4'd0, length_seen} * (CB+4)'(10)
                                  + (CB+4)'(b - hred_pkg::CHAR_ZERO);
                            length_seen = (grown > (CB+4)'(hred_pkg::CNT_MAX)) ?
                                          hred_pkg::CNT_MAX : grown[CB-1:0];
                            parse_phase = hred_pkg::VP_DIGITS;
                        end else if (!(b == hred_pkg::CHAR_SPACE &&
                                       parse_phase == hred_pkg::VP_SPACES)) begin
                            parse_phase = hred_pkg::VP_IDLE;
                        end
                    end
                endcase
                if (b == hred_pkg::CHAR_LF) begin
                    if (line_state == hred_pkg::TERM_LF || line_state == hred_pkg::TERM_CRLF ||
                        line_state == hred_pkg::TERM_CRLFCR) begin
                        line_state  = hred_pkg::TERM_NONE;
                        header_open = 1'b0;
                        parse_phase = hred_pkg::VP_IDLE;
                        name_pos    = 0;
                    end else begin
                        line_state = (line_state == hred_pkg::TERM_CR) ?
                                     hred_pkg::TERM_CRLF : hred_pkg::TERM_LF;
                    end
                end else if (b == hred_pkg::CHAR_CR) begin
                    line_state = (line_state == hred_pkg::TERM_CRLF) ?
                                 hred_pkg::TERM_CRLFCR : hred_pkg::TERM_CR;
                end else begin
                    line_state = hred_pkg::TERM_NONE;
                end
            end else if (length_seen != 0 && body_seen != hred_pkg::CNT_MAX) begin
                body_seen++;
            end
        end
        done = !header_open;
        full = (body_seen == length_seen);
        case (req_method)
            hred_pkg::METH_GET, hred_pkg::METH_DELETE:
                r.stream_end = done && (length_seen == 0 || full);
            hred_pkg::METH_POST, hred_pkg::METH_PUT:
                r.stream_end = done && full;
            default:
                r.stream_end = done && length_seen != 0 && full;
        endcase
        r.method         = req_method;
        r.in_header      = header_open;
        r.content_length = 32'(length_seen);
        r.body_count     = 32'(body_seen);
        return r;
    endfunction

    function automatic string mix_case(string s);
        string t;
        int    i;
        t = s;
        for (i = 0; i < t.len(); i++) begin
            if (((t[i] >= "A" && t[i] <= "Z") || (t[i] >= "a" && t[i] <= "z")) &&
                $urandom_range(0, 1) == 1)
                t[i] = t[i] ^ 8'h20;
        end
        return t;
    endfunction

    task automatic queue_byte(logic [7:0] b);
        pending_bytes.push_back('{op: hred_pkg::OP_DATA, data: b});
    endtask

    task automatic queue_restart();
        pending_bytes.push_back('{op: hred_pkg::OP_RESTART, data: 8'($urandom_range(0, 255))});
    endtask

    task automatic queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0d ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(negedge aclk) begin : drive_requests
        byte_item_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 3);
                s_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                next_item = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_op <= next_item.op;
                s_data_byte <= next_item.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_backpressure
        if (hold_gap > 0) begin
            hold_gap--;
            m_ready <= 1'b0;
        end else if (aresetn && pending_bytes.size() > QUIET_TAIL &&
                     $urandom_range(0, 5) == 0) begin
            hold_gap = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch_results
        request_status_t want;
        if (!aresetn) begin
            item_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0d ns: result item with none expected, got method %0d",
                                 $time, m_method);
                end else begin
                    want = expected_status.pop_front();
                    check_field("method", 32'(want.method), 32'(m_method));
                    check_field("in_header", 32'(want.in_header), 32'(m_in_header));
                    check_field("content_length", want.content_length, m_content_length);
                    check_field("body_count", want.body_count, m_body_count);
                    check_field("stream_end", 32'(want.stream_end), 32'(m_stream_end));
                    results_checked++;
                    if (want.stream_end)
                        ends_seen++;
                end
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(advance_request(s_op, s_data_byte));
                if (s_op == hred_pkg::OP_RESTART)
                    restarts_sent++;
                else
                    bytes_sent++;
            end
            item_taken <= s_valid && s_ready;
        end
    end

    initial begin : run_test
        string       text;
        string       line_end;
        string       field_name;
        string       sep_text;
        string       value;
        int unsigned pick;
        int unsigned want;
        int unsigned body_len;
        int unsigned cut;
        int unsigned n;
        int unsigned i;
        clear_request();

        // directed requests
        queue_restart();
        queue_text({"gEt", eol_lf, eol_lf});
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_restart();
        queue_text({"PuT", eol_crlf, eol_crlf});
        queue_restart();
        queue_text({"DELETE", eol_lf, "content-length", eol_lf, eol_lf});
        queue_restart();
        queue_text({"post", eol_lf, "Content-Length:  2", eol_lf, eol_lf, "abc"});
        queue_restart();
        queue_text("PX");
        queue_restart();
        queue_text({"content-length: 4294967296", eol_lf, eol_lf});
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_restart();

        while (pending_bytes.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n = $urandom_range(1, 16);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 7))
                        0:       queue_restart();
                        1:       queue_byte(hred_pkg::CHAR_CR);
                        2:       queue_byte(hred_pkg::CHAR_LF);
                        default: queue_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end else begin
                line_end = ($urandom_range(0, 3) == 0) ? eol_lf : eol_crlf;
                case ($urandom_range(0, 11))
                    0, 1, 2: text = "GET";
                    3, 4:    text = "POST";
                    5, 6:    text = "PUT";
                    7:       text = "DELETE";
                    8:       text = "HEAD";
                    9: begin
                        case ($urandom_range(0, 4))
                            0:       text = "GE";
                            1:       text = "POS";
                            2:       text = "PUX";
                            3:       text = "DELETX";
                            default: text = "PU";
                        endcase
                    end
                    10:      text = $sformatf("%c", $urandom_range(33, 126));
                    default: text = "";
                endcase
                text = {mix_case(text), " /", $sformatf("%c", $urandom_range(97, 122)),
                        line_end};
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0:       value = "Host: h";
                        1:       value = "Content-Type: t";
                        2:       value = "Accept: */*";
                        default: value = "X-Cc: 1";
                    endcase
                    text = {text, mix_case(value), line_end};
                end
                want = 0;
                if ($urandom_range(0, 9) < 7) begin
                    n = ($urandom_range(0, 3) == 0) ? 2 : 1;
                    for (i = 0; i < n; i++) begin
                        case ($urandom_range(0, 5))
                            0:       field_name = "CContent-Length";
                            1:       field_name = "Content-Lenght";
                            default: field_name = "Content-Length";
                        endcase
                        case ($urandom_range(0, 5))
                            0:       sep_text = ":";
                            1:       sep_text = $sformatf("=%0d", $urandom_range(0, 9));
                            2:       sep_text = ":   ";
                            default: sep_text = ": ";
                        endcase
                        case ($urandom_range(0, 9))
                            0: begin
                                want = $urandom_range(0, 8);
                                value = $sformatf("00%0d", want);
                            end
                            1: begin
                                case ($urandom_range(0, 2))
                                    0:       value = "4294967295";
                                    1:       value = "4294967296";
                                    default: value = "123456789012";
                                endcase
                                want = $urandom_range(0, 6);
                            end
                            2: begin
                                case ($urandom_range(0, 3))
                                    0:       value = "-5";
                                    1:       value = "+5";
                                    2:       value = "1 2";
                                    default: value = "x9";
                                endcase
                                want = $urandom_range(0, 4);
                            end
                            3: value = "0";
                            default: begin
                                want = $urandom_range(1, 24);
                                value = $sformatf("%0d", want);
                            end
                        endcase
                        text = {text, mix_case(field_name), sep_text, value, line_end};
                    end
                end
                // blank line, occasionally with the other line ending
                if ($urandom_range(0, 5) == 0)
                    line_end = (line_end == eol_lf) ? eol_crlf : eol_lf;
                text = {text, line_end};
                if ($urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, text.len());
                    queue_text(text.substr(0, cut - 1));
                    queue_restart();
                end else begin
                    queue_text(text);
                    case ($urandom_range(0, 5))
                        0, 1, 2: body_len = want;
                        3:       body_len = want + $urandom_range(1, 4);
                        4:       body_len = (want > 0) ? want - 1 : 0;
                        default: body_len = $urandom_range(0, 12);
                    endcase
                    for (i = 0; i < body_len; i++)
                        queue_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 6) != 0)
                        queue_restart();
                end
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_status.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run covered %0d data bytes and %0d restarts; %0d status items compared.",
                 bytes_sent, restarts_sent, results_checked);
        $display("%0d status items flagged a complete request; %0d mismatches found.",
                 ends_seen, mismatches);
        if (mismatches == 0)
            $display("http_request_end_detector regression: pass");
        else
            $display("http_request_end_detector regression: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("http_request_end_detector regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hred_pkg.sv
rtl/http_request_end_detector.sv
bench/tb.sv
